FILE: hw/rtl/transfer_completion_tracker_core_assert.svh
// assertion macros for the transfer completion tracker
`ifndef TRANSFER_COMPLETION_TRACKER_CORE_ASSERT_SVH
`define TRANSFER_COMPLETION_TRACKER_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define TCT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tracker check failed: same-cycle implication");

// next-cycle implication, disabled while in reset
`define TCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tracker check failed: next-cycle implication");

`endif

FILE: hw/rtl/tct_pkg.sv
package tct_pkg;

    localparam int CountBits = 16;
    typedef logic [CountBits-1:0] cnt_t;

    // commands
    localparam logic [2:0] CMD_REG_FLUSH   = 3'd0;
    localparam logic [2:0] CMD_FLUSH_DONE  = 3'd1;
    localparam logic [2:0] CMD_CHUNK_DONE  = 3'd2;
    localparam logic [2:0] CMD_SEAL        = 3'd3;
    localparam logic [2:0] CMD_NOTIFY_DONE = 3'd4;
    localparam logic [2:0] CMD_CANCEL      = 3'd5;

    // status codes
    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_INPROG      = 4'd1;
    localparam logic [3:0] ST_BACKEND     = 4'd2;
    localparam logic [3:0] ST_NOT_ALLOWED = 4'd3;
    localparam logic [3:0] ST_CANCELED    = 4'd4;

    // configuration register indexes
    typedef logic [2:0] cfg_idx_t;
    localparam cfg_idx_t REG_EXPECTED_CHUNKS  = 3'd0;
    localparam cfg_idx_t REG_EXPECTED_FLUSHES = 3'd1;
    localparam cfg_idx_t REG_HAS_NOTIFICATION = 3'd2;
    localparam cfg_idx_t REG_OWNER_COOKIE     = 3'd3;
    localparam cfg_idx_t REG_HANDLE_IDENTITY  = 3'd4;
    localparam cfg_idx_t REG_GENERATION_TAG   = 3'd5;
    localparam cfg_idx_t REG_SINK_PRESENT     = 3'd6;

    typedef enum logic [1:0] {
        PH_POSTING  = 2'd0,
        PH_DATA     = 2'd1,
        PH_NOTIFY   = 2'd2,
        PH_TERMINAL = 2'd3
    } phase_t;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [3:0]  event_status;
        logic [63:0] event_time;
        logic        post_present;
    } event_t;

    typedef struct packed {
        logic [3:0]  reply_status;
        logic        result_valid;
        logic [3:0]  result_status;
        logic [63:0] result_time;
        logic [63:0] result_cookie;
        logic [63:0] result_identity;
        logic [63:0] result_generation;
        logic        notify_start;
        logic [1:0]  phase_now;
    } reply_t;

    typedef struct packed {
        phase_t phase;
        logic   posting_sealed;
        logic   result_published;
        cnt_t   flushes_registered;
        cnt_t   flushes_completed;
        cnt_t   chunks_completed;
        logic   poster_held;
        logic   notify_started;
        logic   notify_completed;
    } track_state_t;

endpackage

FILE: hw/rtl/tct_event_if.sv
interface tct_event_if;
    import tct_pkg::*;

    logic   valid;
    logic   ready;
    event_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/tct_reply_if.sv
interface tct_reply_if;
    import tct_pkg::*;

    logic   valid;
    logic   ready;
    reply_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/transfer_completion_tracker_core.sv
// channel   direction  payload
// evt       in         cmd, event_status, event_time, post_present
// rsp       out        reply_status, result_*, notify_start, phase_now
// cfg       in         write enable, index, 64-bit data
//
// one event per cycle while replies are not stalled; each event gives exactly one reply,
// offered once it has passed the input register and then the state update and reply
// register
// reset clears the tracking state and loads register defaults (sink_present is 1)
// a stalled reply holds its register; the input stage keeps taking events while a slot is free
`include "transfer_completion_tracker_core_assert.svh"

module transfer_completion_tracker_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  tct_pkg::cfg_idx_t cfg_index,
    input  logic [63:0]       cfg_data,
    tct_event_if.sink         evt,
    tct_reply_if.source       rsp
);
    import tct_pkg::*;

    logic [15:0]  chunk_goal_reg;
    logic [15:0]  flush_goal_reg;
    logic         notify_en_reg;
    logic [63:0]  cookie_reg;
    logic [63:0]  handle_id_reg;
    logic [63:0]  generation_tag_reg;
    logic         sink_present_reg;

    logic         in_valid_reg;
    event_t       in_reg;
    logic         out_valid_reg;
    reply_t       reply_reg;
    reply_t       reply_next;
    track_state_t state_reg;
    track_state_t state_next;

    logic         proc_go;
    cnt_t         exp_chunks;
    cnt_t         exp_flushes;

    assign exp_chunks  = cnt_t'(chunk_goal_reg);
    assign exp_flushes = cnt_t'(flush_goal_reg);

    assign proc_go   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign evt.ready = !in_valid_reg || proc_go;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = reply_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_goal_reg     <= '0;
            flush_goal_reg     <= '0;
            notify_en_reg      <= 1'b0;
            cookie_reg         <= '0;
            handle_id_reg      <= '0;
            generation_tag_reg <= '0;
            sink_present_reg   <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_EXPECTED_CHUNKS:  chunk_goal_reg     <= cfg_data[15:0];
                REG_EXPECTED_FLUSHES: flush_goal_reg     <= cfg_data[15:0];
                REG_HAS_NOTIFICATION: notify_en_reg      <= cfg_data[0];
                REG_OWNER_COOKIE:     cookie_reg         <= cfg_data;
                REG_HANDLE_IDENTITY:  handle_id_reg      <= cfg_data;
                REG_GENERATION_TAG:   generation_tag_reg <= cfg_data;
                REG_SINK_PRESENT:     sink_present_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // event processing
    always_comb
    begin
        logic       do_term;
        logic       adv;
        logic       fin;
        logic [3:0] term_st;
        logic [3:0] st_in;
        logic [3:0] st_fail;
        logic [3:0] st_cancel;
        logic       bad_seal;

        state_next = state_reg;
        reply_next = '0;
        reply_next.reply_status = ST_NOT_ALLOWED;
        do_term   = 1'b0;
        adv       = 1'b0;
        fin       = 1'b0;
        term_st   = ST_OK;
        st_in     = in_reg.event_status;
        st_fail   = (st_in == ST_OK || st_in == ST_INPROG) ? ST_BACKEND : st_in;
        st_cancel = (st_in == ST_OK || st_in == ST_INPROG) ? ST_CANCELED : st_in;
        bad_seal  = state_reg.phase != PH_POSTING || state_reg.posting_sealed ||
                    state_reg.flushes_registered != exp_flushes ||
                    (notify_en_reg && !in_reg.post_present);

        unique case (in_reg.cmd)
            CMD_REG_FLUSH:
            begin
                if (state_reg.phase == PH_POSTING && !state_reg.posting_sealed &&
                    state_reg.flushes_registered != exp_flushes)
                begin
                    state_next.flushes_registered = state_reg.flushes_registered + cnt_t'(1);
                    reply_next.reply_status = ST_OK;
                end
            end
            CMD_FLUSH_DONE:
            begin
                if (state_reg.phase != PH_TERMINAL)
                begin
                    fin = 1'b1;
                    if (st_in != ST_OK)
                    begin
                        do_term = 1'b1;
                        term_st = st_fail;
                    end
                    else if (state_reg.flushes_completed == exp_flushes)
                    begin
                        do_term = 1'b1;
                        term_st = ST_BACKEND;
                    end
                    else
                    begin
                        state_next.flushes_completed = state_reg.flushes_completed + cnt_t'(1);
                        adv = 1'b1;
                    end
                end
            end
            CMD_CHUNK_DONE:
            begin
                if (state_reg.phase != PH_TERMINAL)
                begin
                    fin = 1'b1;
                    if (st_in != ST_OK)
                    begin
                        do_term = 1'b1;
                        term_st = st_fail;
                    end
                    else if (state_reg.chunks_completed == exp_chunks)
                    begin
                        do_term = 1'b1;
                        term_st = ST_BACKEND;
                    end
                    else
                    begin
                        state_next.chunks_completed = state_reg.chunks_completed + cnt_t'(1);
                        adv = 1'b1;
                    end
                end
            end
            CMD_SEAL:
            begin
                if (bad_seal)
                begin
                    if (state_reg.phase != PH_TERMINAL)
                    begin
                        do_term = 1'b1;
                        term_st = ST_BACKEND;
                    end
                end
                else
                begin
                    state_next.posting_sealed = 1'b1;
                    state_next.phase          = PH_DATA;
                    state_next.poster_held    = in_reg.post_present;
                    adv = 1'b1;
                    fin = 1'b1;
                end
            end
            CMD_NOTIFY_DONE:
            begin
                if (state_reg.phase != PH_TERMINAL)
                begin
                    if (st_in != ST_OK)
                    begin
                        do_term = 1'b1;
                        term_st = st_fail;
                    end
                    else if (state_reg.phase != PH_NOTIFY || !state_reg.notify_started ||
                             state_reg.notify_completed)
                    begin
                        do_term = 1'b1;
                        term_st = ST_BACKEND;
                    end
                    else
                    begin
                        state_next.notify_completed = 1'b1;
                        adv = 1'b1;
                    end
                end
            end
            CMD_CANCEL:
            begin
                if (state_reg.phase != PH_TERMINAL)
                begin
                    do_term = 1'b1;
                    term_st = st_cancel;
                end
            end
            default: ;
        endcase

        // all counts met after seal: finish or move on to notification
        if (adv)
        begin
            reply_next.reply_status = ST_OK;
            if (state_next.posting_sealed && state_next.chunks_completed == exp_chunks &&
                state_next.flushes_completed == exp_flushes)
            begin
                if (notify_en_reg)
                begin
                    state_next.phase = PH_NOTIFY;
                end
                if (!notify_en_reg || state_next.notify_completed)
                begin
                    do_term = 1'b1;
                    term_st = ST_OK;
                end
            end
        end

        if (do_term)
        begin
            state_next.phase = PH_TERMINAL;
            if (state_reg.result_published || !sink_present_reg)
            begin
                reply_next.reply_status = ST_BACKEND;
            end
            else
            begin
                state_next.result_published  = 1'b1;
                reply_next.reply_status      = ST_OK;
                reply_next.result_valid      = 1'b1;
                reply_next.result_status     = term_st;
                reply_next.result_time       = in_reg.event_time;
                reply_next.result_cookie     = cookie_reg;
                reply_next.result_identity   = handle_id_reg;
                reply_next.result_generation = generation_tag_reg;
            end
        end
        else if (fin && state_next.phase == PH_NOTIFY && !state_next.notify_started &&
                 state_next.poster_held)
        begin
            // launch the notification post once
            state_next.notify_started = 1'b1;
            state_next.poster_held    = 1'b0;
            reply_next.notify_start   = 1'b1;
        end

        reply_next.phase_now = state_next.phase;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{phase: PH_POSTING, default: '0};
        end
        else
        begin
            if (evt.ready)
            begin
                in_valid_reg <= evt.valid;
            end
            if (!out_valid_reg || rsp.ready)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (proc_go)
            begin
                state_reg <= state_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (evt.valid && evt.ready)
        begin
            in_reg <= evt.data;
        end
        if (proc_go)
        begin
            reply_reg <= reply_next;
        end
    end

    `TCT_ASSERT_IMPL(a_publish_once, clk, rst_n, proc_go && state_reg.result_published, !reply_next.result_valid)
    `TCT_ASSERT_NEXT(a_terminal_sticky, clk, rst_n, state_reg.phase == PH_TERMINAL, state_reg.phase == PH_TERMINAL)
    `TCT_ASSERT_IMPL(a_start_in_notify, clk, rst_n, proc_go && reply_next.notify_start, state_next.phase == PH_NOTIFY && !state_reg.notify_started)
    `TCT_ASSERT_NEXT(a_start_flag_set, clk, rst_n, proc_go && reply_next.notify_start, state_reg.notify_started && !state_reg.poster_held)

endmodule

FILE: dv/transfer_completion_tracker_core_tb.sv
`timescale 1ns / 100ps

module transfer_completion_tracker_core_tb;
    import tct_pkg::*;

    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    localparam int GAP_LIGHT = 28;
    localparam int GAP_HEAVY = 79;
    localparam int MODE_SWAP_AT = 380;
    localparam int MODE_FREE_AT = 760;
    localparam int HOLD_START = 250;
    localparam int HOLD_CYCLES = 100;
    localparam int STALL_LIMIT = 2000;
    localparam int REPLY_LATENCY = 2;

    typedef struct packed {
        cnt_t        chunk_goal;
        cnt_t        flush_goal;
        logic        notify_en;
        logic [63:0] cookie;
        logic [63:0] handle_id;
        logic [63:0] generation_tag;
        logic        sink_present;
    } tracker_regs_t;

    typedef enum logic [2:0] {
        END_NOTIFY_OK,
        END_NOTIFY_ERR,
        END_CANCEL,
        END_OVERFLOW,
        END_RESEAL,
        END_FLUSH_ERR
    } ending_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    cfg_idx_t    cfg_index;
    logic [63:0] cfg_data;

    tct_event_if evt_bus ();
    tct_reply_if rsp_bus ();

    transfer_completion_tracker_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .evt       (evt_bus.sink),
        .rsp       (rsp_bus.source)
    );

    tracker_regs_t shadow_regs;
    track_state_t  stim_track;
    track_state_t  pred_track;
    event_t        pending_events[$];
    reply_t        expected_replies[$];
    reply_t        predicted;
    reply_t        observed;
    int            n_queued = 0;
    int            n_accepted = 0;
    int            n_errors = 0;
    int            stall_cycles = 0;
    int            ready_cycles = 0;
    logic          evt_took = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // keep the low bits, fill the unused upper bits with junk
    function automatic logic [63:0] padded(input logic [63:0] value, input int bits);
        logic [63:0] mask;
        mask = (64'd1 << bits) - 64'd1;
        return (rand64() & ~mask) | (value & mask);
    endfunction

    function automatic event_t compose_event(input logic [2:0] cmd, input logic [3:0] st,
                                             input logic [63:0] ts, input logic post);
        event_t ev;
        ev.cmd = cmd;
        ev.event_status = st;
        ev.event_time = ts;
        ev.post_present = post;
        return ev;
    endfunction

    function automatic logic [3:0] close_transfer(inout track_state_t s, inout reply_t r,
                                                  input logic [3:0] st, input logic [63:0] ts);
        s.phase = PH_TERMINAL;
        if (s.result_published || !shadow_regs.sink_present)
            return ST_BACKEND;
        s.result_published = 1'b1;
        r.result_valid = 1'b1;
        r.result_status = st;
        r.result_time = ts;
        r.result_cookie = shadow_regs.cookie;
        r.result_identity = shadow_regs.handle_id;
        r.result_generation = shadow_regs.generation_tag;
        return ST_OK;
    endfunction

    function automatic logic [3:0] fail_transfer(inout track_state_t s, inout reply_t r,
                                                 input logic [3:0] st, input logic [63:0] ts);
        if (s.phase == PH_TERMINAL)
            return ST_NOT_ALLOWED;
        // a failure never reports a non-error code
        return close_transfer(s, r, (st == ST_OK || st == ST_INPROG) ? ST_BACKEND : st, ts);
    endfunction

    function automatic logic [3:0] try_finish(inout track_state_t s, inout reply_t r,
                                              input logic [63:0] ts);
        if (!s.posting_sealed || s.chunks_completed != shadow_regs.chunk_goal
                || s.flushes_completed != shadow_regs.flush_goal)
            return ST_OK;
        if (shadow_regs.notify_en)
        begin
            s.phase = PH_NOTIFY;
            if (!s.notify_completed)
                return ST_OK;
        end
        return close_transfer(s, r, ST_OK, ts);
    endfunction

    function automatic logic [3:0] launch_notify(inout track_state_t s, inout reply_t r,
                                                 input logic [3:0] status);
        if (status == ST_OK && s.phase == PH_NOTIFY && !s.notify_started && s.poster_held)
        begin
            s.notify_started = 1'b1;
            s.poster_held = 1'b0;
            r.notify_start = 1'b1;
        end
        return status;
    endfunction

    function automatic reply_t track_event(inout track_state_t s, input event_t ev);
        reply_t     r;
        logic [3:0] st;
        logic [3:0] status;
        cnt_t       done_cnt;
        cnt_t       done_goal;
        r = '0;
        st = ev.event_status;
        status = ST_NOT_ALLOWED;
        case (ev.cmd)
            CMD_REG_FLUSH:
                if (s.phase == PH_POSTING && !s.posting_sealed
                        && s.flushes_registered != shadow_regs.flush_goal)
                begin
                    s.flushes_registered = s.flushes_registered + 1'b1;
                    status = ST_OK;
                end
            CMD_FLUSH_DONE, CMD_CHUNK_DONE:
                if (s.phase != PH_TERMINAL)
                begin
                    if (ev.cmd == CMD_FLUSH_DONE)
                    begin
                        done_cnt = s.flushes_completed;
                        done_goal = shadow_regs.flush_goal;
                    end
                    else
                    begin
                        done_cnt = s.chunks_completed;
                        done_goal = shadow_regs.chunk_goal;
                    end
                    if (st != ST_OK)
                        status = fail_transfer(s, r, st, ev.event_time);
                    else if (done_cnt == done_goal)
                        status = fail_transfer(s, r, ST_BACKEND, ev.event_time);
                    else
                    begin
                        if (ev.cmd == CMD_FLUSH_DONE)
                            s.flushes_completed = done_cnt + 1'b1;
                        else
                            s.chunks_completed = done_cnt + 1'b1;
                        status = try_finish(s, r, ev.event_time);
                    end
                    status = launch_notify(s, r, status);
                end
            CMD_SEAL:
            begin
                if (s.phase != PH_POSTING || s.posting_sealed
                        || s.flushes_registered != shadow_regs.flush_goal
                        || (shadow_regs.notify_en && !ev.post_present))
                    status = fail_transfer(s, r, ST_BACKEND, ev.event_time);
                else
                begin
                    s.posting_sealed = 1'b1;
                    s.phase = PH_DATA;
                    s.poster_held = ev.post_present;
                    status = try_finish(s, r, ev.event_time);
                end
                status = launch_notify(s, r, status);
            end
            CMD_NOTIFY_DONE:
                if (s.phase != PH_TERMINAL)
                begin
                    if (st != ST_OK)
                        status = fail_transfer(s, r, st, ev.event_time);
                    else if (s.phase != PH_NOTIFY || !s.notify_started || s.notify_completed)
                        status = fail_transfer(s, r, ST_BACKEND, ev.event_time);
                    else
                    begin
                        s.notify_completed = 1'b1;
                        status = try_finish(s, r, ev.event_time);
                    end
                end
            CMD_CANCEL:
                status = fail_transfer(s, r,
                    (st == ST_OK || st == ST_INPROG) ? ST_CANCELED : st, ev.event_time);
            default: ;
        endcase
        r.reply_status = status;
        r.phase_now = s.phase;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            n_errors++;
        end
    endfunction

    function automatic int sender_gap_pct();
        if (n_accepted < MODE_SWAP_AT)
            return GAP_LIGHT;
        if (n_accepted < MODE_FREE_AT)
            return GAP_HEAVY;
        return 0;
    endfunction

    function automatic int receiver_gap_pct();
        if (n_accepted < MODE_SWAP_AT)
            return GAP_HEAVY;
        if (n_accepted < MODE_FREE_AT)
            return GAP_LIGHT;
        return 0;
    endfunction

    // request driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            evt_bus.valid <= 1'b0;
            evt_bus.data <= '0;
        end
        else if (!evt_bus.valid || evt_took)
        begin
            if (pending_events.size() > 0 && $urandom_range(99) >= sender_gap_pct())
            begin
                evt_bus.valid <= 1'b1;
                evt_bus.data <= pending_events.pop_front();
            end
            else
                evt_bus.valid <= 1'b0;
        end
    end

    // reply acceptor, with one long hold-off to back the block up
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_bus.ready <= 1'b0;
        else
        begin
            ready_cycles <= ready_cycles + 1;
            if (ready_cycles >= HOLD_START && ready_cycles < HOLD_START + HOLD_CYCLES)
                rsp_bus.ready <= 1'b0;
            else
                rsp_bus.ready <= ($urandom_range(99) >= receiver_gap_pct());
        end
    end

    // monitor, predictor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            evt_took <= evt_bus.valid && evt_bus.ready;
            if (evt_bus.valid && evt_bus.ready)
            begin
                predicted = track_event(pred_track, evt_bus.data);
                expected_replies = {expected_replies, predicted};
                n_accepted++;
            end
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                observed = rsp_bus.data;
                if (expected_replies.size() == 0)
                begin
                    $display("%0t: unexpected reply, expected none, actual %0h", $time, observed);
                    n_errors++;
                end
                else
                begin
                    predicted = expected_replies.pop_front();
                    check_field("reply_status", predicted.reply_status, observed.reply_status);
                    check_field("result_valid", predicted.result_valid, observed.result_valid);
                    check_field("result_status", predicted.result_status, observed.result_status);
                    check_field("result_time", predicted.result_time, observed.result_time);
                    check_field("result_cookie", predicted.result_cookie, observed.result_cookie);
                    check_field("result_identity", predicted.result_identity,
                                observed.result_identity);
                    check_field("result_generation", predicted.result_generation,
                                observed.result_generation);
                    check_field("notify_start", predicted.notify_start, observed.notify_start);
                    check_field("phase_now", predicted.phase_now, observed.phase_now);
                end
            end
            if ((evt_bus.valid && evt_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
                stall_cycles = 0;
            else
            begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT)
                begin
                    $display("%0t: watchdog expired with %0d replies outstanding",
                             $time, expected_replies.size());
                    $display("Verification failed");
                    $finish;
                end
            end
        end
    end

    task automatic push_event(input event_t ev);
        void'(track_event(stim_track, ev));
        pending_events = {pending_events, ev};
        n_queued++;
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [63:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_EXPECTED_CHUNKS:  shadow_regs.chunk_goal = value[CountBits-1:0];
            REG_EXPECTED_FLUSHES: shadow_regs.flush_goal = value[CountBits-1:0];
            REG_HAS_NOTIFICATION: shadow_regs.notify_en = value[0];
            REG_OWNER_COOKIE:     shadow_regs.cookie = value;
            REG_HANDLE_IDENTITY:  shadow_regs.handle_id = value;
            REG_GENERATION_TAG:   shadow_regs.generation_tag = value;
            REG_SINK_PRESENT:     shadow_regs.sink_present = value[0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (n_accepted != n_queued || expected_replies.size() != 0)
            @(negedge clk);
        repeat (REPLY_LATENCY + 1) @(negedge clk);
    endtask

    // well-formed traffic that keeps the transfer alive in posting or data phase
    task automatic push_live_traffic(input int count);
        int pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                push_event(compose_event($urandom_range(1) ? CMD_SPARE_HI : CMD_SPARE_LO,
                    $urandom_range(15), rand64(), $urandom_range(1)));
            else if (pick < 40)
                push_event(compose_event(CMD_REG_FLUSH, $urandom_range(15), rand64(),
                    $urandom_range(1)));
            else if (pick < 65 && stim_track.flushes_completed < stim_track.flushes_registered
                    && stim_track.flushes_completed < shadow_regs.flush_goal)
                push_event(compose_event(CMD_FLUSH_DONE, ST_OK, rand64(), $urandom_range(1)));
            else if (stim_track.chunks_completed < shadow_regs.chunk_goal)
                push_event(compose_event(CMD_CHUNK_DONE, ST_OK, rand64(), $urandom_range(1)));
            else
                push_event(compose_event(CMD_REG_FLUSH, $urandom_range(15), rand64(),
                    $urandom_range(1)));
        end
    endtask

    initial
    begin
        int      flushes_left;
        int      chunks_left;
        ending_t ending;
        evt_bus.valid = 1'b0;
        evt_bus.data = '0;
        rsp_bus.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_EXPECTED_CHUNKS;
        cfg_data = '0;
        rst_n = 1'b0;
        shadow_regs = '0;
        shadow_regs.sink_present = 1'b1;
        stim_track = '0;
        pred_track = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // defaults: only requests that leave the transfer untouched
        push_event(compose_event(CMD_SPARE_LO, 4'hf, '1, 1'b1));
        push_event(compose_event(CMD_SPARE_HI, ST_OK, '0, 1'b0));
        push_event(compose_event(CMD_REG_FLUSH, ST_OK, rand64(), 1'b0));
        drain();

        // wide-open totals so posting can run long
        write_reg(REG_EXPECTED_CHUNKS, padded(64'hffff, CountBits));
        write_reg(REG_EXPECTED_FLUSHES, padded(64'hffff, CountBits));
        write_reg(REG_HAS_NOTIFICATION, padded(64'd0, 1));
        write_reg(REG_OWNER_COOKIE, '1);
        write_reg(REG_HANDLE_IDENTITY, '0);
        write_reg(REG_GENERATION_TAG, rand64());
        write_reg(REG_SINK_PRESENT, padded(64'd0, 1));

        push_event(compose_event(CMD_REG_FLUSH, 4'hf, '0, 1'b1));
        push_event(compose_event(CMD_REG_FLUSH, ST_OK, '1, 1'b0));
        push_event(compose_event(CMD_FLUSH_DONE, ST_OK, '1, 1'b1));
        push_event(compose_event(CMD_CHUNK_DONE, ST_OK, '0, 1'b0));
        push_event(compose_event(CMD_SPARE_HI, 4'h9, rand64(), 1'b1));
        push_live_traffic(400);
        drain();

        // close registration at what was registered, then seal with a poster
        write_reg(REG_EXPECTED_FLUSHES, padded(64'(stim_track.flushes_registered), CountBits));
        write_reg(REG_HAS_NOTIFICATION, padded(64'd1, 1));
        write_reg(REG_SINK_PRESENT, padded(64'd1, 1));
        push_event(compose_event(CMD_REG_FLUSH, ST_INPROG, rand64(), 1'b0));
        push_event(compose_event(CMD_SEAL, ST_OK, rand64(), 1'b1));
        push_event(compose_event(CMD_REG_FLUSH, ST_OK, rand64(), 1'b1));
        push_live_traffic(600);
        drain();

        // bring the chunk total within reach and finish the data phase
        write_reg(REG_EXPECTED_CHUNKS,
            padded(64'(stim_track.chunks_completed) + 64'($urandom_range(4, 1)), CountBits));
        write_reg(REG_OWNER_COOKIE, rand64());
        write_reg(REG_HANDLE_IDENTITY, rand64());
        write_reg(REG_GENERATION_TAG, rand64());
        write_reg(REG_SINK_PRESENT, padded(64'($urandom_range(4) != 0), 1));
        write_reg(REG_HAS_NOTIFICATION, padded(64'($urandom_range(3) != 0), 1));
        flushes_left = shadow_regs.flush_goal - stim_track.flushes_completed;
        chunks_left = shadow_regs.chunk_goal - stim_track.chunks_completed;
        while (flushes_left + chunks_left > 0)
        begin
            if (flushes_left > 0 && (chunks_left == 0 || $urandom_range(1)))
            begin
                push_event(compose_event(CMD_FLUSH_DONE, ST_OK, rand64(), $urandom_range(1)));
                flushes_left--;
            end
            else
            begin
                push_event(compose_event(CMD_CHUNK_DONE, ST_OK, rand64(), $urandom_range(1)));
                chunks_left--;
            end
        end
        push_event(compose_event(CMD_REG_FLUSH, ST_OK, rand64(), 1'b1));
        push_event(compose_event(CMD_SPARE_LO, $urandom_range(15), rand64(), 1'b0));

        // the seed picks how the transfer ends
        ending = $urandom_range(1) ? END_NOTIFY_OK : ending_t'($urandom_range(5));
        case (ending)
            END_NOTIFY_OK:
                push_event(compose_event(CMD_NOTIFY_DONE, ST_OK, rand64(), 1'b0));
            END_NOTIFY_ERR:
                push_event(compose_event(CMD_NOTIFY_DONE, $urandom_range(15, 1), rand64(), 1'b0));
            END_CANCEL:
                push_event(compose_event(CMD_CANCEL, $urandom_range(15), rand64(), 1'b1));
            END_OVERFLOW:
                push_event(compose_event(CMD_CHUNK_DONE, ST_OK, rand64(), 1'b0));
            END_RESEAL:
                push_event(compose_event(CMD_SEAL, ST_OK, rand64(), $urandom_range(1)));
            END_FLUSH_ERR:
                push_event(compose_event(CMD_FLUSH_DONE, $urandom_range(15, 1), rand64(), 1'b0));
            default: ;
        endcase
        drain();

        // terminal: everything is refused whatever the registers say
        write_reg(REG_EXPECTED_CHUNKS, padded(64'd0, CountBits));
        write_reg(REG_EXPECTED_FLUSHES, padded(64'd0, CountBits));
        write_reg(REG_SINK_PRESENT, padded(64'(!shadow_regs.sink_present), 1));
        push_event(compose_event(CMD_CANCEL, ST_OK, '1, 1'b1));
        push_event(compose_event(CMD_NOTIFY_DONE, ST_OK, '0, 1'b0));
        for (int i = 0; i < 130; i++)
            push_event(compose_event($urandom_range(7), $urandom_range(15), rand64(),
                $urandom_range(1)));
        drain();

        repeat (2 * REPLY_LATENCY + 4) @(negedge clk);
        if (n_errors == 0 && expected_replies.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
